/* rtl/kcl_pkg.sv */
package kcl_pkg;

  // Number of key characters in one code
  localparam int unsigned CODE_DIGITS = 4;

  localparam int unsigned KEY_W = 8;
  localparam int unsigned IDX_W = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
  localparam int unsigned CNT_W = $clog2(CODE_DIGITS + 1);

  localparam int unsigned EVENT_W  = 3;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned DIGITS_W = 3;

  localparam logic [KEY_W-1:0] KEY_ENTER  = 8'h2b;  // '+'
  localparam logic [KEY_W-1:0] KEY_CHANGE = 8'h2d;  // '-'
  localparam logic [KEY_W-1:0] KEY_ONE    = 8'h31;  // '1'

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE    = 3'd0,
    EV_OPEN    = 3'd1,
    EV_ALARM   = 3'd2,
    EV_CHANGED = 3'd3,
    EV_ASK_NEW = 3'd4
  } event_e;

  typedef struct packed {
    logic [DIGITS_W-1:0] digits_taken;
    logic [MODE_W-1:0]   mode_now;
    event_e              event_res;
  } kcl_res_t;

  // digit count shown modulo 8
  function automatic logic [DIGITS_W-1:0] count_out(logic [CNT_W-1:0] c);
    logic [CNT_W+DIGITS_W-1:0] w;
    w = {{DIGITS_W{1'b0}}, c};
    return w[DIGITS_W-1:0];
  endfunction

endpackage

/* rtl/kcl_core.sv */
module kcl_core import kcl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             key_valid_i,
  input  logic [KEY_W-1:0] key_i,
  output kcl_res_t         res_o
);

  typedef enum logic [MODE_W-1:0] {
    MODE_MENU  = 2'd0,
    MODE_ENTER = 2'd1,
    MODE_OLD   = 2'd2,
    MODE_NEW   = 2'd3
  } mode_e;

  mode_e            mode_q, mode_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [KEY_W-1:0] entry_q  [CODE_DIGITS];
  logic [KEY_W-1:0] stored_q [CODE_DIGITS];

  logic [CNT_W-1:0] pos;
  logic [CNT_W-1:0] pos_inc;
  logic [IDX_W-1:0] idx;
  logic             last_digit;
  logic             match;
  event_e           ev;

  // clamp is defensive; count never passes CODE_DIGITS-1
  assign pos     = (cnt_q >= CNT_W'(CODE_DIGITS)) ? CNT_W'(CODE_DIGITS - 1) : cnt_q;
  assign pos_inc = pos + CNT_W'(1);
  assign idx     = pos[IDX_W-1:0];
  assign last_digit = (pos_inc >= CNT_W'(CODE_DIGITS));

  // compare includes the key arriving now
  always_comb begin
    match = 1'b1;
    for (int i = 0; i < CODE_DIGITS; i++) begin
      if (IDX_W'(i) == idx) begin
        if (key_i != stored_q[i]) match = 1'b0;
      end else if (entry_q[i] != stored_q[i]) begin
        match = 1'b0;
      end
    end
  end

  always_comb begin
    mode_d = mode_q;
    cnt_d  = cnt_q;
    ev     = EV_NONE;
    case (mode_q)
      MODE_MENU: begin
        if (key_i == KEY_ENTER) begin
          mode_d = MODE_ENTER;
          cnt_d  = '0;
        end else if (key_i == KEY_CHANGE) begin
          mode_d = MODE_OLD;
          cnt_d  = '0;
        end
      end
      MODE_ENTER: begin
        cnt_d = pos_inc;
        if (last_digit) begin
          cnt_d  = '0;
          mode_d = MODE_MENU;
          ev     = match ? EV_OPEN : EV_ALARM;
        end
      end
      MODE_OLD: begin
        cnt_d = pos_inc;
        if (last_digit) begin
          cnt_d  = '0;
          mode_d = match ? MODE_NEW : MODE_MENU;
          ev     = match ? EV_ASK_NEW : EV_ALARM;
        end
      end
      MODE_NEW: begin
        cnt_d = pos_inc;
        if (last_digit) begin
          cnt_d  = '0;
          mode_d = MODE_MENU;
          ev     = EV_CHANGED;
        end
      end
      default: begin
        mode_d = MODE_MENU;
        cnt_d  = '0;
      end
    endcase
  end

  always_comb begin
    res_o.event_res    = ev;
    res_o.mode_now     = mode_d;
    res_o.digits_taken = (mode_d == MODE_MENU) ? '0 : count_out(cnt_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_MENU;
      cnt_q  <= '0;
      for (int i = 0; i < CODE_DIGITS; i++) begin
        stored_q[i] <= KEY_ONE + KEY_W'(i % 4);
      end
    end else if (key_valid_i) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      if (mode_q == MODE_NEW) stored_q[idx] <= key_i;
    end
  end

  // entry buffer: payload only, read only after being written in the same entry
  always_ff @(posedge clk_i) begin
    if (key_valid_i && (mode_q == MODE_ENTER || mode_q == MODE_OLD)) begin
      entry_q[idx] <= key_i;
    end
  end

endmodule

/* rtl/keypad_code_lock.sv */
// Keypad code lock.
// Slave stream: one key character per transaction, s_axis_tdata[7:0] = ASCII key.
// Master stream: exactly one result transaction per key, tdata packed as
//   [2:0] event (none, open, alarm, changed, ask new code), [4:3] mode after
//   the key, [7:5] digits collected in the current entry.
// In the menu '+' starts code entry, '-' starts a code change; any other key
// there gives an empty event. During entry every key counts as a digit.
// The result of a key is registered and is on the master side in the cycle after
// its transaction. Throughput: one key per cycle while the receiver takes each
// result, set by the single state update between key transaction and result register.
// Reset (asynchronous, active low) returns to the menu with count zero and the
// stored code "1234"; no clearing pass, the block is ready straight away.
// While the receiver stalls, the result register holds and s_axis_tready drops;
// a new key is taken in the same cycle the waiting result is taken.
module keypad_code_lock import kcl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] key_char
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [2:0] event_res, [4:3] mode_now, [7:5] digits_taken
);

  logic     key_acc;
  kcl_res_t res;
  kcl_res_t res_q;
  logic     valid_q;

  // output register empty, or being emptied this cycle
  assign s_axis_tready = !valid_q || m_axis_tready;
  assign key_acc       = s_axis_tvalid && s_axis_tready;

  kcl_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_valid_i (key_acc),
    .key_i       (s_axis_tdata[KEY_W-1:0]),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      valid_q <= s_axis_tvalid;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (key_acc) res_q <= res;
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = res_q;

endmodule

/* rtl/kcl_checker.sv */
module kcl_checker import kcl_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [7:0] s_axis_tdata,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  localparam logic [MODE_W-1:0] MODE_MENU = 2'd0;

  // every key yields its result on the next cycle
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
    else $error("result missing after key transaction");

  // no key taken while a result waits unclaimed
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("key taken over stalled result");

  // a finished entry always leaves a zero digit count
  a_event_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[2:0] != EV_NONE) |-> (m_axis_tdata[7:5] == '0))
    else $error("event with non-zero digit count");

  // open or alarm always returns to the menu
  a_event_menu: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[2:0] == EV_OPEN || m_axis_tdata[2:0] == EV_ALARM))
    |-> (m_axis_tdata[4:3] == MODE_MENU))
    else $error("open or alarm outside the menu");

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind keypad_code_lock kcl_checker u_kcl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
